// File: hw/rtl/dpms_pkg.sv
// Shared types, constants and the saturation helper for the plant model step block.
// Used by the top level and its checker; depends on nothing else.
`default_nettype none

package dpms_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int WIDE_W = 66;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  localparam logic [1:0] MODEL_FIRST  = 2'd0;
  localparam logic [1:0] MODEL_SECOND = 2'd1;
  localparam logic [1:0] MODEL_INTEG  = 2'd2;
  localparam logic [1:0] MODEL_DEAD   = 2'd3;

  localparam logic [2:0] REG_MODEL = 3'd0;
  localparam logic [2:0] REG_GAIN  = 3'd1;
  localparam logic [2:0] REG_TAU   = 3'd2;
  localparam logic [2:0] REG_WN    = 3'd3;
  localparam logic [2:0] REG_ZETA  = 3'd4;
  localparam logic [2:0] REG_THETA = 3'd5;
  localparam logic [2:0] REG_DT    = 3'd6;
  localparam logic [2:0] REG_START = 3'd7;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam wide_t VMAX = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t VMIN = -VMAX - wide_t'(1);

  function automatic sat_t sat_fn(input wide_t x);
    sat_t r;
    if (x > VMAX) begin
      r.clip = 1'b1;
      r.val  = VMAX[DATA_W-1:0];
    end else if (x < VMIN) begin
      r.clip = 1'b1;
      r.val  = VMIN[DATA_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/discrete_plant_model_step.sv
// Plant model step: Euler-integrated first-order, second-order, integrating and dead-time plant.
// Depends on dpms_pkg and dpms_ram.
// One shared 32x32 multiplier serves all products, and a 63-step restoring divider forms the
// first-order lag step and, for the dead-time model, the delay length; restart and zero step
// size skip the arithmetic and go straight to the result.
// The block takes one word at a time; the result waits in an output register.
`default_nettype none

module discrete_plant_model_step #(
  parameter int MAX_DELAY = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic signed [31:0] control_input_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] process_value_o,
  output logic             saturated_o
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FW = $clog2(MAX_DELAY + 1);
  localparam int DW = dpms_pkg::DATA_W;

  typedef enum logic [4:0] {
    S_IDLE, S_F_KU, S_F_KU2, S_F_MD, S_F_MD2, S_DIV, S_DIV_END, S_F_FIN,
    S_I_KU, S_I_KU2, S_I_D, S_I_D2,
    S_M_A, S_M_B, S_M_C, S_M_D, S_M_E, S_M_F, S_M_G, S_M_H, S_M_I, S_M_J, S_M_K,
    S_D_CMP, S_D_RD, S_DONE
  } state_e;

  state_e state_q;

  logic [1:0]           model_q;
  logic signed [DW-1:0] gain_q, start_q;
  logic [30:0]          tau_q, wn_q, zeta_q, theta_q, dt_q;

  logic signed [DW-1:0] y_q, v_q, u_q, ud_q, ta_q, tb_q, tc_q, td_q;
  logic signed [34:0]   acc_q;
  logic                 clip_q;
  logic [AW-1:0]        head_q;
  logic [FW-1:0]        fill_q;

  logic signed [63:0]   prod_q;
  logic signed [DW-1:0] mul_a, mul_b;

  logic [62:0]          num_q;
  logic [31:0]          den_q, rem_q;
  logic [5:0]           cnt_q;
  logic                 phase_q, neg_q;

  logic                 out_valid_q, sat_q;
  logic signed [DW-1:0] pv_q;
  logic                 done_go;

  logic [AW-1:0]        raddr, waddr;
  logic                 we;
  logic [DW-1:0]        rdata;

  logic signed [63:0]   psh;
  dpms_pkg::sat_t       ms;
  logic [32:0]          rsh, rdiff;
  logic [FW-1:0]        n_cl, f_mod;
  logic [AW:0]          idx_w;
  logic [AW-1:0]        head_inc;

  assign psh   = prod_q >>> dpms_pkg::FRAC_W;
  assign ms    = dpms_pkg::sat_fn(dpms_pkg::wide_t'(psh));
  assign rsh   = {rem_q, num_q[62]};
  assign rdiff = rsh - {1'b0, den_q};

  assign n_cl  = (num_q > 63'(MAX_DELAY)) ? FW'(MAX_DELAY) : num_q[FW-1:0];
  assign f_mod = (fill_q == FW'(MAX_DELAY)) ? '0 : fill_q;
  assign idx_w = ({1'b0, head_q} >= (AW+1)'(f_mod)) ?
                 ({1'b0, head_q} - (AW+1)'(f_mod)) :
                 ({1'b0, head_q} + (AW+1)'(MAX_DELAY) - (AW+1)'(f_mod));
  assign raddr = idx_w[AW-1:0];
  assign head_inc = (head_q == AW'(MAX_DELAY - 1)) ? '0 : head_q + AW'(1);
  assign waddr = head_q;
  assign we    = (state_q == S_D_RD) ||
                 ((state_q == S_D_CMP) && !((FW+1)'(fill_q) + (FW+1)'(1) > (FW+1)'(n_cl)));
  assign done_go = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    mul_a = gain_q;
    mul_b = ud_q;
    unique case (state_q)
      S_F_MD:  begin mul_a = ta_q;                  mul_b = $signed({1'b0, dt_q}); end
      S_I_KU:  begin mul_a = gain_q;                mul_b = u_q; end
      S_I_D:   begin mul_a = ta_q;                  mul_b = $signed({1'b0, dt_q}); end
      S_M_A:   begin mul_a = $signed({1'b0, wn_q}); mul_b = $signed({1'b0, wn_q}); end
      S_M_B:   begin mul_a = $signed({1'b0, zeta_q}); mul_b = $signed({1'b0, wn_q}); end
      S_M_C:   begin mul_a = v_q;                   mul_b = $signed({1'b0, dt_q}); end
      S_M_D:   begin mul_a = ta_q;                  mul_b = y_q; end
      S_M_E:   begin mul_a = tb_q;                  mul_b = v_q; end
      S_M_F:   begin mul_a = gain_q;                mul_b = ta_q; end
      S_M_H:   begin mul_a = ta_q;                  mul_b = u_q; end
      S_M_J:   begin mul_a = tb_q;                  mul_b = $signed({1'b0, dt_q}); end
      default: begin mul_a = gain_q;                mul_b = ud_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  dpms_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_DELAY)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(u_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    dpms_pkg::sat_t s1;
    dpms_pkg::sat_t s2;
    logic signed [63:0] qs;
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      model_q     <= dpms_pkg::MODEL_FIRST;
      gain_q      <= 32'sd65536;
      tau_q       <= 31'd65536;
      wn_q        <= 31'd65536;
      zeta_q      <= 31'd65536;
      theta_q     <= '0;
      dt_q        <= 31'd655;
      start_q     <= '0;
      y_q         <= '0;
      v_q         <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          dpms_pkg::REG_MODEL: model_q <= cfg_wdata_i[1:0];
          dpms_pkg::REG_GAIN:  gain_q  <= $signed(cfg_wdata_i);
          dpms_pkg::REG_TAU:   tau_q   <= cfg_wdata_i[30:0];
          dpms_pkg::REG_WN:    wn_q    <= cfg_wdata_i[30:0];
          dpms_pkg::REG_ZETA:  zeta_q  <= cfg_wdata_i[30:0];
          dpms_pkg::REG_THETA: theta_q <= cfg_wdata_i[30:0];
          dpms_pkg::REG_DT:    dt_q    <= cfg_wdata_i[30:0];
          dpms_pkg::REG_START: start_q <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            u_q    <= control_input_i;
            ud_q   <= control_input_i;
            clip_q <= 1'b0;
            if (op_i == dpms_pkg::OP_RESTART) begin
              y_q     <= start_q;
              v_q     <= '0;
              head_q  <= '0;
              fill_q  <= '0;
              state_q <= S_DONE;
            end else if (dt_q == '0) begin
              state_q <= S_DONE;
            end else begin
              unique case (model_q)
                dpms_pkg::MODEL_FIRST:  state_q <= S_F_KU;
                dpms_pkg::MODEL_SECOND: state_q <= S_M_A;
                dpms_pkg::MODEL_INTEG:  state_q <= S_I_KU;
                default: begin
                  num_q   <= 63'({theta_q, 1'b0}) + 63'(dt_q);
                  den_q   <= {dt_q, 1'b0};
                  rem_q   <= '0;
                  cnt_q   <= '0;
                  phase_q <= 1'b0;
                  state_q <= S_DIV;
                end
              endcase
            end
          end
        end
        S_F_KU:  state_q <= S_F_KU2;
        S_F_KU2: begin
          if (tau_q == '0) begin
            y_q     <= ms.val;
            clip_q  <= clip_q | ms.clip;
            state_q <= S_DONE;
          end else begin
            s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(ms.val) - dpms_pkg::wide_t'(y_q));
            ta_q    <= s1.val;
            clip_q  <= clip_q | ms.clip | s1.clip;
            state_q <= S_F_MD;
          end
        end
        S_F_MD:  state_q <= S_F_MD2;
        S_F_MD2: begin
          neg_q   <= prod_q[63];
          num_q   <= prod_q[63] ? 63'(-prod_q) : prod_q[62:0];
          den_q   <= {1'b0, tau_q};
          rem_q   <= '0;
          cnt_q   <= '0;
          phase_q <= 1'b1;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!rdiff[32]) begin
            rem_q <= rdiff[31:0];
          end else begin
            rem_q <= rsh[31:0];
          end
          num_q <= {num_q[61:0], !rdiff[32]};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd62) begin
            state_q <= S_DIV_END;
          end
        end
        S_DIV_END: state_q <= phase_q ? S_F_FIN : S_D_CMP;
        S_F_FIN: begin
          qs      = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(qs));
          s2      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(y_q) + dpms_pkg::wide_t'(s1.val));
          y_q     <= s2.val;
          clip_q  <= clip_q | s1.clip | s2.clip;
          state_q <= S_DONE;
        end
        S_I_KU:  state_q <= S_I_KU2;
        S_I_KU2: begin
          ta_q    <= ms.val;
          clip_q  <= clip_q | ms.clip;
          state_q <= S_I_D;
        end
        S_I_D:   state_q <= S_I_D2;
        S_I_D2: begin
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(y_q) + dpms_pkg::wide_t'(ms.val));
          y_q     <= s1.val;
          clip_q  <= clip_q | ms.clip | s1.clip;
          state_q <= S_DONE;
        end
        S_M_A: state_q <= S_M_B;
        S_M_B: begin
          ta_q    <= ms.val;
          clip_q  <= clip_q | ms.clip;
          state_q <= S_M_C;
        end
        S_M_C: begin
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(ms.val) + dpms_pkg::wide_t'(ms.val));
          tb_q    <= s1.val;
          clip_q  <= clip_q | ms.clip | s1.clip;
          state_q <= S_M_D;
        end
        S_M_D: begin
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(y_q) + dpms_pkg::wide_t'(ms.val));
          tc_q    <= s1.val;
          clip_q  <= clip_q | ms.clip | s1.clip;
          state_q <= S_M_E;
        end
        S_M_E: begin
          td_q    <= ms.val;
          clip_q  <= clip_q | ms.clip;
          state_q <= S_M_F;
        end
        S_M_F: begin
          acc_q   <= -35'(td_q) - 35'(ms.val);
          clip_q  <= clip_q | ms.clip;
          state_q <= S_M_G;
        end
        S_M_G: begin
          ta_q    <= ms.val;
          clip_q  <= clip_q | ms.clip;
          state_q <= S_M_H;
        end
        S_M_H: state_q <= S_M_I;
        S_M_I: begin
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(acc_q) + dpms_pkg::wide_t'(ms.val));
          tb_q    <= s1.val;
          clip_q  <= clip_q | ms.clip | s1.clip;
          state_q <= S_M_J;
        end
        S_M_J: state_q <= S_M_K;
        S_M_K: begin
          s1      = dpms_pkg::sat_fn(dpms_pkg::wide_t'(v_q) + dpms_pkg::wide_t'(ms.val));
          v_q     <= s1.val;
          y_q     <= tc_q;
          clip_q  <= clip_q | ms.clip | s1.clip;
          state_q <= S_DONE;
        end
        S_D_CMP: begin
          if ((FW+1)'(fill_q) + (FW+1)'(1) > (FW+1)'(n_cl)) begin
            if (fill_q == '0) begin
              state_q <= S_F_KU;
            end else begin
              state_q <= S_D_RD;
            end
          end else begin
            ud_q    <= '0;
            head_q  <= head_inc;
            fill_q  <= fill_q + FW'(1);
            state_q <= S_F_KU;
          end
        end
        S_D_RD: begin
          ud_q    <= $signed(rdata);
          head_q  <= head_inc;
          state_q <= S_F_KU;
        end
        S_DONE: begin
          if (done_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_go) begin
      pv_q  <= y_q;
      sat_q <= clip_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign process_value_o = pv_q;
  assign saturated_o     = sat_q;

endmodule

`default_nettype wire

// File: hw/rtl/dpms_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module dpms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/dpms_checker.sv
// Port-level checker for the plant model step block, bound to the top level.
// Depends on discrete_plant_model_step.
`default_nettype none

module dpms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] process_value_o,
  input wire logic        saturated_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(process_value_o) &&
    $stable(saturated_o))
    else $error("result word changed while stalled");

  // The block works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // A result appears only as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && !$past(in_ready_o))
    else $error("result without finished work");

endmodule

bind discrete_plant_model_step dpms_checker u_dpms_checker (.*);

`default_nettype wire

// File: bench/discrete_plant_model_step_chk.sv
// Checker for the plant model step block: tracks register writes, predicts each result word
// from the accepted input words and compares it with the block's output. Depends on dpms_pkg.
`timescale 1ns / 100ps

module discrete_plant_model_step_chk #(
  parameter int MAX_DELAY = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic               op_i,
  input  wire logic signed [31:0] control_input_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] process_value_i,
  input  wire logic               saturated_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam longint PV_MAX = 64'sd2147483647;
  localparam longint PV_MIN = -64'sd2147483648;
  localparam int     EXP_DEPTH = 4;

  typedef struct packed {
    logic signed [31:0] pv;
    logic               sat;
  } plant_out_t;

  logic [1:0] model_q;
  longint     gain_q, tau_q, wn_q, zeta_q, theta_q, dt_q, start_q;
  longint     pos_q, vel_q;
  longint     ring_q [MAX_DELAY];
  int         head_q, fill_q;
  bit         clipped;
  plant_out_t expected_q [EXP_DEPTH];
  int         wr_cnt, rd_cnt;

  function automatic longint clamp_pv(input longint x);
    if (x > PV_MAX) begin
      clipped = 1'b1;
      return PV_MAX;
    end
    if (x < PV_MIN) begin
      clipped = 1'b1;
      return PV_MIN;
    end
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp_pv(p >>> dpms_pkg::FRAC_W);
  endfunction

  function automatic void lag_step(input longint u);
    longint ku, e, d;
    ku = qmul(gain_q, u);
    if (tau_q == 0) begin
      pos_q = ku;
    end else begin
      e = clamp_pv(ku - pos_q);
      d = clamp_pv((e * dt_q) / tau_q);
      pos_q = clamp_pv(pos_q + d);
    end
  endfunction

  function automatic void spring_step(input longint u);
    longint x1, x2, w2, c, a;
    x1 = pos_q;
    x2 = vel_q;
    w2 = qmul(wn_q, wn_q);
    c = clamp_pv(2 * qmul(zeta_q, wn_q));
    a = clamp_pv(-qmul(w2, x1) - qmul(c, x2) + qmul(qmul(gain_q, w2), u));
    pos_q = clamp_pv(x1 + qmul(x2, dt_q));
    vel_q = clamp_pv(x2 + qmul(a, dt_q));
  endfunction

  function automatic void delayed_lag_step(input longint u);
    longint n, ud;
    int     idx;
    n = (2 * theta_q + dt_q) / (2 * dt_q);
    ud = 0;
    if (n > MAX_DELAY) n = MAX_DELAY;
    if (fill_q + 1 > n) begin
      if (fill_q == 0) begin
        ud = u;
      end else begin
        idx = (head_q + MAX_DELAY - (fill_q % MAX_DELAY)) % MAX_DELAY;
        ud = ring_q[idx];
        ring_q[head_q] = u;
        head_q = (head_q + 1) % MAX_DELAY;
      end
    end else begin
      ring_q[head_q] = u;
      head_q = (head_q + 1) % MAX_DELAY;
      fill_q++;
    end
    lag_step(ud);
  endfunction

  function automatic plant_out_t predict_plant(input logic op, input longint u);
    plant_out_t r;
    clipped = 1'b0;
    if (op == dpms_pkg::OP_RESTART) begin
      pos_q = start_q;
      vel_q = 0;
      head_q = 0;
      fill_q = 0;
    end else if (dt_q != 0) begin
      case (model_q)
        dpms_pkg::MODEL_FIRST:  lag_step(u);
        dpms_pkg::MODEL_SECOND: spring_step(u);
        dpms_pkg::MODEL_INTEG:  pos_q = clamp_pv(pos_q + qmul(qmul(gain_q, u), dt_q));
        default:                delayed_lag_step(u);
      endcase
    end
    r.pv = pos_q[31:0];
    r.sat = clipped;
    return r;
  endfunction

  assign pending_o = wr_cnt - rd_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    plant_out_t want;
    if (!rst_ni) begin
      model_q <= dpms_pkg::MODEL_FIRST;
      gain_q = 65536;
      tau_q = 65536;
      wn_q = 65536;
      zeta_q = 65536;
      theta_q = 0;
      dt_q = 655;
      start_q = 0;
      pos_q = 0;
      vel_q = 0;
      head_q = 0;
      fill_q = 0;
      errors_o <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          dpms_pkg::REG_MODEL: model_q <= cfg_wdata_i[1:0];
          dpms_pkg::REG_GAIN:  gain_q = longint'($signed(cfg_wdata_i));
          dpms_pkg::REG_TAU:   tau_q = longint'(cfg_wdata_i[30:0]);
          dpms_pkg::REG_WN:    wn_q = longint'(cfg_wdata_i[30:0]);
          dpms_pkg::REG_ZETA:  zeta_q = longint'(cfg_wdata_i[30:0]);
          dpms_pkg::REG_THETA: theta_q = longint'(cfg_wdata_i[30:0]);
          dpms_pkg::REG_DT:    dt_q = longint'(cfg_wdata_i[30:0]);
          default:             start_q = longint'($signed(cfg_wdata_i));
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_q[wr_cnt % EXP_DEPTH] <= predict_plant(op_i, longint'(control_input_i));
        wr_cnt <= wr_cnt + 1;
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_cnt == rd_cnt) begin
          if (errors_o < 10)
            $display("%0t: result word with none expected: pv=%0d sat=%0b",
                     $realtime, process_value_i, saturated_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q[rd_cnt % EXP_DEPTH];
          rd_cnt <= rd_cnt + 1;
          if (want.pv !== process_value_i || want.sat !== saturated_i) begin
            if (errors_o < 10)
              $display("%0t: mismatch: expected pv=%0d sat=%0b, got pv=%0d sat=%0b",
                       $realtime, want.pv, want.sat, process_value_i, saturated_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: bench/discrete_plant_model_step_tb.sv
// Top of the plant model step testbench: clock, reset, register setup and input words with
// random idling; the checker module judges results. Depends on dpms_pkg and the block's RTL.
`timescale 1ns / 100ps

module discrete_plant_model_step_tb;

  localparam int WATCHDOG_CYCLES = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_addr_i = dpms_pkg::REG_MODEL;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               op_i = dpms_pkg::OP_STEP;
  logic signed [31:0] control_input_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o, out_valid_o, saturated_o;
  logic signed [31:0] process_value_o;
  int                 errors, pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;

  discrete_plant_model_step dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .op_i, .control_input_i,
    .out_valid_o, .out_ready_i, .process_value_o, .saturated_o
  );

  discrete_plant_model_step_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .control_input_i,
    .out_valid_i(out_valid_o), .out_ready_i, .process_value_i(process_value_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic signed [31:0] u);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    control_input_i <= u;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic cfg_end();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_u31(input int p, input int typ_max);
    case (p)
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      default: return $urandom_range(typ_max);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_s32(input int p, input int span);
    case (p)
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(2 * span)) - span;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_sample();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(1310720)) - 655360;
  endfunction

  initial begin
    int          sel, idle_mode;
    logic [31:0] dt, theta;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(dpms_pkg::OP_RESTART, 32'sd0);
    send_word(dpms_pkg::OP_STEP, 32'sh7fff_ffff);
    send_word(dpms_pkg::OP_STEP, 32'sh8000_0000);
    send_word(dpms_pkg::OP_STEP, 32'sd0);
    send_word(dpms_pkg::OP_STEP, -32'sd1);
    drain_results();
    cfg_write(dpms_pkg::REG_TAU, 32'd0);
    cfg_end();
    send_word(dpms_pkg::OP_STEP, 32'sh7fff_ffff);
    send_word(dpms_pkg::OP_STEP, 32'sh8000_0000);
    drain_results();
    cfg_write(dpms_pkg::REG_MODEL, 32'(dpms_pkg::MODEL_SECOND));
    cfg_write(dpms_pkg::REG_START, 32'sh0001_0000);
    cfg_end();
    send_word(dpms_pkg::OP_RESTART, 32'sd0);
    send_word(dpms_pkg::OP_STEP, 32'sh0002_0000);
    send_word(dpms_pkg::OP_STEP, 32'sh7fff_ffff);
    drain_results();
    cfg_write(dpms_pkg::REG_MODEL, 32'(dpms_pkg::MODEL_INTEG));
    cfg_end();
    send_word(dpms_pkg::OP_STEP, 32'sh8000_0000);
    send_word(dpms_pkg::OP_STEP, 32'sh0001_0000);
    drain_results();
    cfg_write(dpms_pkg::REG_MODEL, 32'(dpms_pkg::MODEL_DEAD));
    cfg_write(dpms_pkg::REG_TAU, 32'd65536);
    cfg_write(dpms_pkg::REG_THETA, 32'd1965);
    cfg_end();
    for (int i = 0; i < 5; i++) send_word(dpms_pkg::OP_STEP, 32'sh0001_0000 * (i + 1));
    send_word(dpms_pkg::OP_RESTART, 32'sd0);
    send_word(dpms_pkg::OP_STEP, 32'sh0003_0000);
    drain_results();
    cfg_write(dpms_pkg::REG_DT, 32'd0);
    cfg_end();
    send_word(dpms_pkg::OP_STEP, 32'sh0005_0000);
    send_word(dpms_pkg::OP_RESTART, 32'sd0);
    drain_results();

    for (int p = 0; p < 16; p++) begin
      sel = (p == 1) ? 1 : (p == 2) ? 2 : 3 + $urandom_range(9);
      dt = (sel < 3) ? pick_u31(sel, 0) :
           ($urandom_range(9) == 0) ? pick_u31(1 + $urandom_range(1), 0) :
           1 + $urandom_range(6552);
      theta = (p == 5) ? 32'h7fff_ffff : (p == 6) ? 32'd0 : dt * $urandom_range(20);
      theta[31] = 1'b0;
      cfg_write(dpms_pkg::REG_MODEL, 32'(p % 4));
      cfg_write(dpms_pkg::REG_GAIN, pick_s32(sel, 262144));
      cfg_write(dpms_pkg::REG_TAU, pick_u31(sel, 262144));
      cfg_write(dpms_pkg::REG_WN, pick_u31(sel, 262144));
      cfg_write(dpms_pkg::REG_ZETA, pick_u31(sel, 131072));
      cfg_write(dpms_pkg::REG_THETA, theta);
      cfg_write(dpms_pkg::REG_DT, dt);
      cfg_write(dpms_pkg::REG_START, pick_s32(sel, 655360));
      cfg_end();
      idle_mode = (p / 4 + p) % 4;
      send_idle_pct = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 18 : 0;
      stall_pct = (idle_mode == 2) ? 49 : (idle_mode == 3) ? 18 : 0;
      if ($urandom_range(1) == 0) send_word(dpms_pkg::OP_RESTART, rand_sample());
      for (int i = 0; i < 50; i++)
        send_word(($urandom_range(19) == 0) ? dpms_pkg::OP_RESTART : dpms_pkg::OP_STEP,
                  rand_sample());
      drain_results();
      stall_pct = 0;
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
